[rtl/itoa_pkg.sv]
// Package for the signed integer to decimal ASCII converter.
// Holds the sequencer state type, character codes, the powers-of-ten table
// and the control struct for the compare-subtract unit. No dependencies.
package itoa_pkg;

  // Character codes
  localparam logic [7:0] CharZero  = 8'd48;
  localparam logic [7:0] CharMinus = 8'd45;

  // Decimal digit positions of a 32-bit magnitude (10^9 .. 10^0)
  localparam int unsigned NumDigits = 10;
  localparam int unsigned DigitIdxW = 4;
  // Bits of one decimal digit, resolved one per cycle (weights 8, 4, 2, 1)
  localparam int unsigned DigitBits = 4;
  localparam int unsigned BitIdxW   = 2;
  // Trial value width: 8 * 10^9 needs 33 bits, keep headroom for the shift
  localparam int unsigned TrialW    = 35;

  typedef enum logic [1:0] {
    StIdle,
    StSign,
    StCalc,
    StEmit
  } itoa_state_e;

  // Control of the compare-subtract unit
  typedef struct packed {
    logic                 load;
    logic                 step;
    logic [DigitIdxW-1:0] digit_idx;
    logic [BitIdxW-1:0]   bit_idx;
  } csub_ctrl_t;

  // Powers of ten; unused codes read as one
  function automatic logic [31:0] pow10(input logic [DigitIdxW-1:0] idx);
    logic [31:0] p;
    case (idx)
      4'd0:    p = 32'd1;
      4'd1:    p = 32'd10;
      4'd2:    p = 32'd100;
      4'd3:    p = 32'd1000;
      4'd4:    p = 32'd10000;
      4'd5:    p = 32'd100000;
      4'd6:    p = 32'd1000000;
      4'd7:    p = 32'd10000000;
      4'd8:    p = 32'd100000000;
      4'd9:    p = 32'd1000000000;
      default: p = 32'd1;
    endcase
    return p;
  endfunction

endpackage

[rtl/itoa_in_if.sv]
// Input channel of the converter: valid/ready handshake with a 32-bit signed value.
// No dependencies.
interface itoa_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

[rtl/itoa_out_if.sv]
// Output channel of the converter: valid/ready handshake with one ASCII
// character and an end-of-text marker. No dependencies.
interface itoa_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

[rtl/itoa_csub.sv]
// Shared compare-subtract unit: holds the running remainder and, per step,
// subtracts (weight * 10^digit) when it fits. Depends on itoa_pkg.
module itoa_csub (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  itoa_pkg::csub_ctrl_t ctrl_i,
  input  logic [31:0]          load_val_i,
  output logic                 ge_o
);
  import itoa_pkg::*;

  logic [31:0]     rem_q, rem_d;
  logic [TrialW-1:0] trial;

  // Trial value = 10^digit shifted by the bit weight
  assign trial = TrialW'(pow10(ctrl_i.digit_idx)) << ctrl_i.bit_idx;
  assign ge_o  = {{(TrialW-32){1'b0}}, rem_q} >= trial;

  // Remainder update
  always_comb begin
    rem_d = rem_q;
    if (ctrl_i.load) begin
      rem_d = load_val_i;
    end else if (ctrl_i.step && ge_o) begin
      rem_d = rem_q - trial[31:0];
    end
  end

  // Remainder register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else begin
      rem_q <= rem_d;
    end
  end
endmodule

[rtl/signed_int_to_decimal_ascii_core.sv]
// Top level of the signed integer to decimal ASCII converter.
// Depends on itoa_pkg, itoa_in_if, itoa_out_if and itoa_csub.
//
// Usage:
//   in_i  : one 32-bit two's complement value per transaction (valid/ready).
//   out_o : the decimal text, one ASCII character per transaction, most
//           significant first; last marks the final character. A negative
//           value starts with '-'; no leading zeros; zero gives "0".
// Timing:
//   in_i.ready is high only while the block is idle; one value is converted
//   at a time. Each of the ten decimal digit positions is resolved on the
//   shared compare-subtract unit one digit bit at a time (weights 8/4/2/1),
//   and each digit that is shown is offered on out_o once it is resolved
//   (up to 11 characters with the sign). For negative values the first
//   character ('-') appears in the cycle after the accept.
// Stalls:
//   A character is held on out_o, stable, until out_o.ready takes it; the
//   sequencer waits meanwhile.
// Reset:
//   rst_ni (asynchronous, active low) returns the sequencer to idle; any
//   conversion in progress is dropped.
module signed_int_to_decimal_ascii_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  itoa_in_if.sink    in_i,
  itoa_out_if.source out_o
);
  import itoa_pkg::*;

  itoa_state_e          state_q, state_d;
  logic [DigitIdxW-1:0] didx_q, didx_d;
  logic [BitIdxW-1:0]   bidx_q, bidx_d;
  logic [DigitBits-1:0] digit_q, digit_d;
  logic                 started_q, started_d;
  logic                 ge;
  logic [DigitBits-1:0] digit_new;
  logic                 digit_show;
  logic                 in_acc;
  logic                 out_acc;
  logic [31:0]          mag;
  csub_ctrl_t           ctrl;

  assign in_acc  = in_i.valid && in_i.ready;
  assign out_acc = out_o.valid && out_o.ready;

  // Magnitude in unsigned arithmetic; the most negative value maps to 2^31
  assign mag = in_i.value[31] ? (32'd0 - 32'(in_i.value)) : 32'(in_i.value);

  // Digit with the current bit resolved
  assign digit_new  = ge ? (digit_q | (DigitBits'(1) << bidx_q)) : digit_q;
  // Show a digit once nonzero text has begun, or the units digit always
  assign digit_show = (digit_new != '0) || started_q || (didx_q == '0);

  // Shared compare-subtract unit
  assign ctrl.load      = in_acc;
  assign ctrl.step      = (state_q == StCalc);
  assign ctrl.digit_idx = didx_q;
  assign ctrl.bit_idx   = bidx_q;

  itoa_csub u_csub (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .load_val_i (mag),
    .ge_o       (ge)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_acc) state_d = in_i.value[31] ? StSign : StCalc;
      end
      StSign: begin
        if (out_acc) state_d = StCalc;
      end
      StCalc: begin
        if (bidx_q == '0 && digit_show) state_d = StEmit;
      end
      StEmit: begin
        if (out_acc) state_d = (didx_q == '0) ? StIdle : StCalc;
      end
      default: state_d = StIdle;
    endcase
  end

  // Sequencer counters and digit accumulation
  always_comb begin
    didx_d    = didx_q;
    bidx_d    = bidx_q;
    digit_d   = digit_q;
    started_d = started_q;
    case (state_q)
      StIdle: begin
        if (in_acc) begin
          didx_d    = DigitIdxW'(NumDigits - 1);
          bidx_d    = BitIdxW'(DigitBits - 1);
          digit_d   = '0;
          started_d = 1'b0;
        end
      end
      StCalc: begin
        digit_d = digit_new;
        if (bidx_q == '0) begin
          if (digit_show) begin
            started_d = 1'b1;
          end else begin
            // leading zero: drop it and move to the next position
            didx_d  = didx_q - DigitIdxW'(1);
            bidx_d  = BitIdxW'(DigitBits - 1);
            digit_d = '0;
          end
        end else begin
          bidx_d = bidx_q - BitIdxW'(1);
        end
      end
      StEmit: begin
        if (out_acc && didx_q != '0) begin
          didx_d  = didx_q - DigitIdxW'(1);
          bidx_d  = BitIdxW'(DigitBits - 1);
          digit_d = '0;
        end
      end
      default: ;
    endcase
  end

  // Channel outputs
  always_comb begin
    in_i.ready      = 1'b0;
    out_o.valid     = 1'b0;
    out_o.character = CharZero + {4'd0, digit_q};
    out_o.last      = 1'b0;
    case (state_q)
      StIdle: in_i.ready = 1'b1;
      StSign: begin
        out_o.valid     = 1'b1;
        out_o.character = CharMinus;
      end
      StEmit: begin
        out_o.valid = 1'b1;
        out_o.last  = (didx_q == '0);
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      didx_q    <= '0;
      bidx_q    <= '0;
      started_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      didx_q    <= didx_d;
      bidx_q    <= bidx_d;
      started_q <= started_d;
    end
  end

  // Digit payload register
  always_ff @(posedge clk_i) begin
    digit_q <= digit_d;
  end
endmodule

[rtl/itoa_checker.sv]
// Port-level checker for the converter, bound to the top level.
// Depends on itoa_pkg and signed_int_to_decimal_ascii_core.
module itoa_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_char_i,
  input logic       out_last_i
);
  import itoa_pkg::*;

  // A waiting character holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_char_i) && $stable(out_last_i))
    else $error("output changed while stalled");

  // One conversion at a time: no input taken while text is shown
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_i && out_valid_i))
    else $error("input ready while output valid");

  // After the final character is taken, the block is ready again
  a_ready_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && out_last_i |=> in_ready_i)
    else $error("not ready after final character");

  // Only '-' or a digit leaves, and '-' is never the final character
  a_char_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_char_i == CharMinus && !out_last_i) ||
                    (out_char_i >= CharZero && out_char_i <= CharZero + 8'd9))
    else $error("bad character code");

  // An accepted value is not followed by an immediate ready
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("ready right after accept");
endmodule

bind signed_int_to_decimal_ascii_core itoa_checker u_itoa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_char_i  (out_o.character),
  .out_last_i  (out_o.last)
);

[tb/tb.sv]
`timescale 1ns / 100ps
// Testbench for signed_int_to_decimal_ascii_core: random valid/ready traffic with a
// self-checking predictor of the decimal ASCII text of each value.
// Depends on itoa_pkg, itoa_in_if, itoa_out_if and the core itself.
module tb;
  import itoa_pkg::*;

  localparam int unsigned IdleLimit   = 2000;  // cycles with no transaction at all
  localparam int unsigned HoldStart   = 400;   // cycle of the long receiver stall
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned QuietItems  = 20;    // last values are sent without gaps
  localparam int unsigned DrainCycles = 60;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } ascii_char_t;

  logic clk_i;
  logic rst_ni;

  itoa_in_if  in_ch ();
  itoa_out_if out_ch ();

  signed_int_to_decimal_ascii_core u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  logic signed [31:0] pending_values[$];
  ascii_char_t        expected_text[$];
  int unsigned        mismatches;
  int unsigned        values_sent;
  int unsigned        negatives_sent;
  int unsigned        chars_checked;
  logic [11:1]        lengths_seen;
  logic               hold_active;

  // clock
  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // Predicted decimal text of one value, appended to expected_text
  function automatic void format_decimal(input logic [31:0] word);
    logic [31:0] mag;
    logic [31:0] rem;
    logic [3:0]  digits[10];
    int          ndig;
    ascii_char_t ch;
    ndig = 0;
    // magnitude in unsigned arithmetic: the most negative value maps to 2^31
    mag = word[31] ? (32'd0 - word) : word;
    do begin
      rem = mag % 32'd10;
      digits[ndig] = rem[3:0];
      mag = mag / 32'd10;
      ndig++;
    end while (mag != 32'd0);
    if (word[31]) begin
      ch.character = CharMinus;
      ch.last      = 1'b0;
      expected_text.push_back(ch);
      negatives_sent++;
    end
    for (int k = ndig - 1; k >= 0; k--) begin
      ch.character = CharZero + {4'd0, digits[k]};
      ch.last      = (k == 0);
      expected_text.push_back(ch);
    end
    lengths_seen[ndig + int'(word[31])] = 1'b1;
  endfunction

  // Random value: mostly a random digit count with a random sign, some full range
  function automatic logic [31:0] random_value();
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned pow;
    longint unsigned mag;
    int unsigned     ndig;
    if ($urandom_range(0, 7) == 0) return $urandom;
    ndig = $urandom_range(1, 10);
    pow = 1;
    repeat (ndig - 1) pow = pow * 10;
    lo = (ndig == 1) ? 0 : pow;
    hi = pow * 10 - 1;
    if (hi > 64'd2147483647) hi = 64'd2147483647;
    mag = lo + (longint'($urandom) % (hi - lo + 1));
    if ($urandom_range(0, 1) == 1) return 32'd0 - mag[31:0];
    return mag[31:0];
  endfunction

  // Driver: offer values from pending_values, predict on each accepted transaction
  always @(posedge clk_i) begin : drive_proc
    int unsigned send_gap;
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) begin
        format_decimal(in_ch.value);
        values_sent++;
      end
      if (in_ch.valid && !in_ch.ready) begin
        // hold the current value until taken
      end else if (send_gap > 0) begin
        send_gap--;
        in_ch.valid <= 1'b0;
      end else if (pending_values.size() > 0) begin
        if (pending_values.size() > QuietItems && $urandom_range(0, 5) == 0) begin
          send_gap = $urandom_range(1, 3) - 1;
          in_ch.valid <= 1'b0;
        end else begin
          in_ch.valid <= 1'b1;
          in_ch.value <= pending_values.pop_front();
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end else begin
      send_gap = 0;
    end
  end

  // Monitor: check each character transaction against the oldest expectation
  always @(posedge clk_i) begin : check_proc
    int unsigned recv_gap;
    ascii_char_t want;
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        chars_checked++;
        if (expected_text.size() == 0) begin
          report_mismatch($sformatf("unexpected character 0x%02h last=%0b",
                                    out_ch.character, out_ch.last));
        end else begin
          want = expected_text.pop_front();
          if (out_ch.character !== want.character)
            report_mismatch($sformatf("character 0x%02h, expected 0x%02h",
                                      out_ch.character, want.character));
          if (out_ch.last !== want.last)
            report_mismatch($sformatf("last %0b, expected %0b on character 0x%02h",
                                      out_ch.last, want.last, want.character));
        end
      end
      if (hold_active) begin
        out_ch.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_ch.ready <= 1'b0;
      end else if (pending_values.size() > QuietItems && $urandom_range(0, 4) == 0) begin
        recv_gap = $urandom_range(1, 3) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end else begin
      recv_gap = 0;
    end
  end

  // One long receiver stall while the sender keeps offering values
  always @(posedge clk_i) begin : holdoff_proc
    int unsigned cycle_cnt;
    if (!rst_ni) begin
      cycle_cnt = 0;
      hold_active <= 1'b0;
    end else begin
      cycle_cnt++;
      hold_active <= (cycle_cnt >= HoldStart) && (cycle_cnt < HoldStart + HoldCycles);
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk_i) begin : watchdog_proc
    int unsigned idle_cycles;
    if (!rst_ni) begin
      idle_cycles = 0;
    end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("Timeout: no transaction for %0d cycles", idle_cycles);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Reset, stimulus and end of run
  initial begin : stimulus
    in_ch.valid  = 1'b0;
    in_ch.value  = '0;
    out_ch.ready = 1'b0;
    mismatches     = 0;
    values_sent    = 0;
    negatives_sent = 0;
    chars_checked  = 0;
    lengths_seen   = '0;
    rst_ni = 1'b0;

    // zero, single digits, digit-count boundaries, both extremes, bit patterns
    pending_values.push_back(32'sd0);
    pending_values.push_back(32'sd1);
    pending_values.push_back(-32'sd1);
    pending_values.push_back(32'sd9);
    pending_values.push_back(-32'sd9);
    pending_values.push_back(32'sd10);
    pending_values.push_back(-32'sd10);
    pending_values.push_back(32'sd99);
    pending_values.push_back(32'sd100);
    pending_values.push_back(32'sd12345);
    pending_values.push_back(-32'sd12345);
    pending_values.push_back(32'sd999999999);
    pending_values.push_back(32'sd1000000000);
    pending_values.push_back(-32'sd1000000000);
    pending_values.push_back(32'sd1000000001);
    pending_values.push_back(32'sd1999999999);
    pending_values.push_back(-32'sd2000000000);
    pending_values.push_back(32'sd2147483647);
    pending_values.push_back(-32'sd2147483647);
    pending_values.push_back(32'h8000_0000);   // most negative value
    pending_values.push_back(32'h5555_5555);
    pending_values.push_back(32'hAAAA_AAAA);
    repeat (98) pending_values.push_back(random_value());

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_values.size() != 0 || in_ch.valid) @(negedge clk_i);
    while (expected_text.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);

    $display("Converted %0d values (%0d negative), checked %0d characters",
             values_sent, negatives_sent, chars_checked);
    $display("Text lengths covered (bit n = n characters): %b, with one long output stall",
             lengths_seen);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
